// File: hw/rtl/efpt_pkg.sv
// Shared types, constants and arithmetic helpers of the ego pose frame transform.
package efpt_pkg;

   // Fixed widths of the pose fields and internal values
   localparam int ANG_W   = 26;
   localparam int SPD_W   = 24;
   localparam int RATE_W  = 25;
   localparam int MAT_W   = 34;
   localparam int VAL_W   = 62;
   localparam int WIDE_W  = 72;
   localparam int PP_W    = 66;

   typedef logic signed [ANG_W-1:0]  ang_type;
   typedef logic signed [MAT_W-1:0]  mat_type;
   typedef logic signed [VAL_W-1:0]  val_type;
   typedef logic signed [WIDE_W-1:0] wide_type;
   typedef logic signed [PP_W-1:0]   pp_type;

   // Register indexes of the configuration port
   typedef enum logic [2:0] {
      REG_POSE_X,
      REG_POSE_Y,
      REG_POSE_Z,
      REG_POSE_YAW,
      REG_POSE_PITCH,
      REG_POSE_ROLL,
      REG_EGO_SPEED,
      REG_EGO_YAW_RATE
   } csr_index_type;

   // Transform modes
   typedef enum logic [1:0] {
      MODE_PT2WORLD,
      MODE_WORLD2PT,
      MODE_VEL2WORLD,
      MODE_VEL2VEH
   } mode_type;

   // Angle constants, degrees in Q16
   localparam logic signed [26:0] A360 = 27'sd23592960;
   localparam logic signed [26:0] A720 = 27'sd47185920;
   localparam logic [24:0] D90  = 25'd5898240;
   localparam logic [24:0] D180 = 25'd11796480;
   localparam logic [24:0] D270 = 25'd17694720;
   localparam logic [22:0] D45F = 23'd2949120;
   localparam logic [22:0] D90F = 23'd5898240;

   // pi/180 in Q32
   localparam logic [26:0] DEG2RAD_K = 27'd74961321;
   localparam logic [30:0] Q30_ONE   = 31'h4000_0000;

   // Taylor divisors and their reciprocals floor(2^32 / k); the last sine entry, unused, is zero
   localparam int SC_STEPS  = 6;
   localparam int SIN_STEPS = 5;
   localparam logic [7:0]  KS [SC_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6, 8'd1};
   localparam logic [31:0] MS [SC_STEPS] = '{32'd39045157, 32'd59652323, 32'd102261126,
                                             32'd214748364, 32'd715827882, 32'd0};
   localparam logic [7:0]  KC [SC_STEPS] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
   localparam logic [31:0] MC [SC_STEPS] = '{32'd32537631, 32'd47721858, 32'd76695844,
                                             32'd143165576, 32'd357913941,
                                             32'd2147483648};

   // Sine/cosine pipeline lane
   typedef struct packed {
      logic [29:0] x;
      logic [29:0] x2;
      logic [30:0] ts;
      logic [30:0] tc;
      logic [1:0]  quad;
      logic        swap;
   } sc_lane_type;

   // Latency of the sine/cosine unit and settle time after a pose write
   localparam int SC_LAT  = 19;
   localparam int MAT_LAT = 2;
   localparam int CFG_LAT = SC_LAT + MAT_LAT + 1;
   localparam int CNT_W   = 5;

   // Internal saturation limits
   localparam wide_type V_MAX = 72'sh1FFF_FFFF_FFFF_FFFF;
   localparam wide_type V_MIN = -72'sh2000_0000_0000_0000;

   // floor(v / k) by reciprocal multiply and one correction
   function automatic logic [30:0] div_k(input logic [30:0] v, input logic [7:0] k,
                                         input logic [31:0] m);
      logic [62:0] prod;
      logic [30:0] q;
      logic [38:0] qk;
      logic [30:0] rem;
      prod = 63'(v) * 63'(m);
      q    = prod[62:32];
      qk   = 39'(q) * 39'(k);
      rem  = v - qk[30:0];
      if (rem >= 31'(k)) begin
         q = q + 31'd1;
      end
      return q;
   endfunction

   // Q30 product, floored
   function automatic mat_type qmul(input mat_type a, input mat_type b);
      logic signed [67:0] p;
      p = 68'(a) * 68'(b);
      return p[63:30];
   endfunction

   // Partial products of a matrix entry with the low and high halves of a value
   function automatic pp_type pp_lo(input mat_type m, input val_type v);
      return pp_type'(m) * pp_type'($signed({1'b0, v[30:0]}));
   endfunction

   function automatic pp_type pp_hi(input mat_type m, input val_type v);
      return pp_type'(m) * pp_type'($signed(v[61:31]));
   endfunction

   // Combine partial products of a three-term row and floor by 2^30
   function automatic wide_type dot_fin(input pp_type l0, input pp_type l1, input pp_type l2,
                                        input pp_type h0, input pp_type h1, input pp_type h2);
      logic signed [99:0] acc;
      acc = 100'(l0) + 100'(l1) + 100'(l2)
          + (100'(h0) <<< 31) + (100'(h1) <<< 31) + (100'(h2) <<< 31);
      return wide_type'(acc >>> 30);
   endfunction

   function automatic val_type sat62(input wide_type v);
      if (v > V_MAX) begin
         return V_MAX[61:0];
      end else if (v < V_MIN) begin
         return V_MIN[61:0];
      end
      return v[61:0];
   endfunction

   function automatic logic ovf62(input wide_type v);
      return (v > V_MAX) || (v < V_MIN);
   endfunction

endpackage

// File: hw/rtl/ego_pose_frame_transform.sv
// Top level of the ego pose frame transform: pose registers, rotation matrix and item pipeline.
//
// Software writes the pose through the csr_ port (index, data; csr_ready is always high).
// Each word on the req_ channel carries a mode and a vector; the block returns one word on
// the rsp_ channel with the transformed vector, saturated per component, and a flag that
// tells whether any clamp took effect.
// Modes: point to world R*p+t, world to point R'*(p-t), velocity to world R*(v+e),
// velocity to vehicle R'*v-e, with R = Rz(yaw)*Ry(pitch)*Rx(roll).
// An accepted word passes the item pipeline stages in order, from input clamp to output clamp.
// Throughput: one word per cycle while req_stall is low; the nine-stage item pipeline takes
// a new word while results wait, and a stall on rsp_ holds the words that cannot advance
// while bubbles close. The rotation matrix comes from a free-running sine/cosine pipeline
// fed by the pose registers; after reset and after every pose write req_stall stays high
// while that pipeline settles.
// Reset clears the pose registers and empties the item pipeline.
module ego_pose_frame_transform #(
   parameter int COORD_WIDTH = 48
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [2:0]             csr_index,
   input  logic [COORD_WIDTH-1:0] csr_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_type,
   input  logic [COORD_WIDTH-1:0] req_vec_x,
   input  logic [COORD_WIDTH-1:0] req_vec_y,
   input  logic [COORD_WIDTH-1:0] req_vec_z,
   input  logic [COORD_WIDTH-1:0] req_obj_pos_x,
   input  logic [COORD_WIDTH-1:0] req_obj_pos_y,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [COORD_WIDTH-1:0] rsp_out_x,
   output logic [COORD_WIDTH-1:0] rsp_out_y,
   output logic [COORD_WIDTH-1:0] rsp_out_z,
   output logic                   rsp_saturated
);

   localparam int NST = 9;
   localparam efpt_pkg::wide_type OUT_MAX =
      (efpt_pkg::wide_type'(1) <<< (COORD_WIDTH - 1)) - efpt_pkg::wide_type'(1);
   localparam efpt_pkg::wide_type OUT_MIN = -OUT_MAX - efpt_pkg::wide_type'(1);

   function automatic efpt_pkg::wide_type ext_cw(input logic [COORD_WIDTH-1:0] v);
      return efpt_pkg::wide_type'($signed(v));
   endfunction

   // ---------------- pose registers ----------------
   logic [COORD_WIDTH-1:0]        pose_ff [3];
   efpt_pkg::ang_type             yaw_ff, pitch_ff, roll_ff;
   logic signed [efpt_pkg::SPD_W-1:0]  speed_ff;
   logic signed [efpt_pkg::RATE_W-1:0] rate_ff;
   logic [efpt_pkg::CNT_W-1:0]    cnt_ff;
   logic                          busy;
   logic                          csr_fire;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   // Write the addressed register
   always_ff @(posedge clock) begin
      if (reset) begin
         pose_ff[0] <= '0;
         pose_ff[1] <= '0;
         pose_ff[2] <= '0;
         yaw_ff     <= '0;
         pitch_ff   <= '0;
         roll_ff    <= '0;
         speed_ff   <= '0;
         rate_ff    <= '0;
      end else if (csr_fire) begin
         unique case (efpt_pkg::csr_index_type'(csr_index))
            efpt_pkg::REG_POSE_X:       pose_ff[0] <= csr_data;
            efpt_pkg::REG_POSE_Y:       pose_ff[1] <= csr_data;
            efpt_pkg::REG_POSE_Z:       pose_ff[2] <= csr_data;
            efpt_pkg::REG_POSE_YAW:     yaw_ff     <= csr_data[efpt_pkg::ANG_W-1:0];
            efpt_pkg::REG_POSE_PITCH:   pitch_ff   <= csr_data[efpt_pkg::ANG_W-1:0];
            efpt_pkg::REG_POSE_ROLL:    roll_ff    <= csr_data[efpt_pkg::ANG_W-1:0];
            efpt_pkg::REG_EGO_SPEED:    speed_ff   <= csr_data[efpt_pkg::SPD_W-1:0];
            efpt_pkg::REG_EGO_YAW_RATE: rate_ff    <= csr_data[efpt_pkg::RATE_W-1:0];
            default:                    rate_ff    <= rate_ff;
         endcase
      end
   end

   // Hold off items until the matrix reflects the current pose
   always_ff @(posedge clock) begin
      if (reset || csr_fire) begin
         cnt_ff <= efpt_pkg::CNT_W'(efpt_pkg::CFG_LAT);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign busy = (cnt_ff != '0);

   // ---------------- rotation matrix ----------------
   efpt_pkg::mat_type sy, cy, sp, cp, sr, cr;
   efpt_pkg::mat_type cysp_ff, sysp_ff, sycr_ff, sysr_ff, cycr_ff, cysr_ff;
   efpt_pkg::mat_type r00_ff, r10_ff, r20_ff, r21_ff, r22_ff, sr_ff, cr_ff;
   efpt_pkg::mat_type mat_ff [3][3];
   efpt_pkg::mat_type w_ff;
   logic signed [52:0] wprod;

   efpt_sincos u_yaw   (.clock(clock), .angle(yaw_ff),   .sin_out(sy), .cos_out(cy));
   efpt_sincos u_pitch (.clock(clock), .angle(pitch_ff), .sin_out(sp), .cos_out(cp));
   efpt_sincos u_roll  (.clock(clock), .angle(roll_ff),  .sin_out(sr), .cos_out(cr));

   assign wprod = 53'(rate_ff) * $signed({26'd0, efpt_pkg::DEG2RAD_K});

   // First products of the matrix, yaw rate in rad/s
   always_ff @(posedge clock) begin
      cysp_ff <= efpt_pkg::qmul(cy, sp);
      sysp_ff <= efpt_pkg::qmul(sy, sp);
      sycr_ff <= efpt_pkg::qmul(sy, cr);
      sysr_ff <= efpt_pkg::qmul(sy, sr);
      cycr_ff <= efpt_pkg::qmul(cy, cr);
      cysr_ff <= efpt_pkg::qmul(cy, sr);
      r00_ff  <= efpt_pkg::qmul(cy, cp);
      r10_ff  <= efpt_pkg::qmul(sy, cp);
      r20_ff  <= -sp;
      r21_ff  <= efpt_pkg::qmul(cp, sr);
      r22_ff  <= efpt_pkg::qmul(cp, cr);
      sr_ff   <= sr;
      cr_ff   <= cr;
      w_ff    <= wprod[51:18];
   end

   // Finish the matrix
   always_ff @(posedge clock) begin
      mat_ff[0][0] <= r00_ff;
      mat_ff[0][1] <= efpt_pkg::qmul(cysp_ff, sr_ff) - sycr_ff;
      mat_ff[0][2] <= efpt_pkg::qmul(cysp_ff, cr_ff) + sysr_ff;
      mat_ff[1][0] <= r10_ff;
      mat_ff[1][1] <= efpt_pkg::qmul(sysp_ff, sr_ff) + cycr_ff;
      mat_ff[1][2] <= efpt_pkg::qmul(sysp_ff, cr_ff) - cysr_ff;
      mat_ff[2][0] <= r20_ff;
      mat_ff[2][1] <= r21_ff;
      mat_ff[2][2] <= r22_ff;
   end

   // Translation and speed at internal width
   efpt_pkg::val_type  t62 [3];
   efpt_pkg::wide_type speed_w;
   logic               t_ovf;

   always_comb begin
      t_ovf = 1'b0;
      for (int j = 0; j < 3; j++) begin
         t62[j] = efpt_pkg::sat62(ext_cw(pose_ff[j]));
         t_ovf  = t_ovf | efpt_pkg::ovf62(ext_cw(pose_ff[j]));
      end
      speed_w = efpt_pkg::wide_type'(speed_ff);
   end

   // ---------------- item pipeline control ----------------
   logic vld_ff [1:NST];
   logic rdy    [1:NST];

   always_comb begin
      rdy[NST] = !vld_ff[NST] || !rsp_stall;
      for (int k = NST - 1; k >= 1; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign req_stall = busy || !rdy[1];
   assign rsp_valid = vld_ff[NST];

   // Advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= NST; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         if (rdy[1]) begin
            vld_ff[1] <= req_valid && !busy;
         end
         for (int k = 2; k <= NST; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // ---------------- stage 1: clamp inputs ----------------
   efpt_pkg::mode_type mode_in;
   efpt_pkg::val_type  v_in [3];
   efpt_pkg::val_type  px_in, py_in;
   logic               flag1_in;
   logic [COORD_WIDTH-1:0] vec_raw [3];

   efpt_pkg::mode_type m1_ff, m2_ff, m3_ff, m4_ff;
   efpt_pkg::val_type  v1_ff [3];
   efpt_pkg::val_type  v2_ff [3];
   efpt_pkg::val_type  v3_ff [3];
   efpt_pkg::val_type  v4_ff [3];
   efpt_pkg::val_type  px1_ff, py1_ff;
   logic               f1_ff, f2_ff, f3_ff, f4_ff, f5_ff, f6_ff, f7_ff, f8_ff;

   assign vec_raw[0] = req_vec_x;
   assign vec_raw[1] = req_vec_y;
   assign vec_raw[2] = req_vec_z;

   always_comb begin
      mode_in  = efpt_pkg::mode_type'(req_type);
      flag1_in = t_ovf;
      for (int j = 0; j < 3; j++) begin
         v_in[j]  = efpt_pkg::sat62(ext_cw(vec_raw[j]));
         flag1_in = flag1_in | efpt_pkg::ovf62(ext_cw(vec_raw[j]));
      end
      px_in = efpt_pkg::sat62(ext_cw(req_obj_pos_x));
      py_in = efpt_pkg::sat62(ext_cw(req_obj_pos_y));
      if (mode_in == efpt_pkg::MODE_VEL2WORLD || mode_in == efpt_pkg::MODE_VEL2VEH) begin
         flag1_in = flag1_in | efpt_pkg::ovf62(ext_cw(req_obj_pos_x))
                             | efpt_pkg::ovf62(ext_cw(req_obj_pos_y));
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         m1_ff  <= mode_in;
         v1_ff  <= v_in;
         px1_ff <= px_in;
         py1_ff <= py_in;
         f1_ff  <= flag1_in;
      end
   end

   // ---------------- stage 2: yaw rate products ----------------
   efpt_pkg::pp_type pxl2_ff, pxh2_ff, pyl2_ff, pyh2_ff;

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         m2_ff   <= m1_ff;
         v2_ff   <= v1_ff;
         f2_ff   <= f1_ff;
         pxl2_ff <= efpt_pkg::pp_lo(w_ff, px1_ff);
         pxh2_ff <= efpt_pkg::pp_hi(w_ff, px1_ff);
         pyl2_ff <= efpt_pkg::pp_lo(w_ff, py1_ff);
         pyh2_ff <= efpt_pkg::pp_hi(w_ff, py1_ff);
      end
   end

   // ---------------- stage 3: finish w*px, w*py ----------------
   efpt_pkg::wide_type dpx_w, dpy_w;
   efpt_pkg::val_type  dpx3_ff, dpy3_ff;
   logic               vel2, vel3;

   assign vel2  = (m2_ff == efpt_pkg::MODE_VEL2WORLD) || (m2_ff == efpt_pkg::MODE_VEL2VEH);
   assign dpx_w = efpt_pkg::dot_fin(pxl2_ff, '0, '0, pxh2_ff, '0, '0);
   assign dpy_w = efpt_pkg::dot_fin(pyl2_ff, '0, '0, pyh2_ff, '0, '0);

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         m3_ff   <= m2_ff;
         v3_ff   <= v2_ff;
         dpx3_ff <= efpt_pkg::sat62(dpx_w);
         dpy3_ff <= efpt_pkg::sat62(dpy_w);
         f3_ff   <= f2_ff | (vel2 & (efpt_pkg::ovf62(dpx_w) | efpt_pkg::ovf62(dpy_w)));
      end
   end

   // ---------------- stage 4: ego motion term ----------------
   efpt_pkg::wide_type e0_w;
   efpt_pkg::val_type  e0_4_ff, e1_4_ff;

   assign vel3 = (m3_ff == efpt_pkg::MODE_VEL2WORLD) || (m3_ff == efpt_pkg::MODE_VEL2VEH);
   assign e0_w = speed_w - efpt_pkg::wide_type'(dpy3_ff);

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         m4_ff   <= m3_ff;
         v4_ff   <= v3_ff;
         e0_4_ff <= efpt_pkg::sat62(e0_w);
         e1_4_ff <= dpx3_ff;
         f4_ff   <= f3_ff | (vel3 & efpt_pkg::ovf62(e0_w));
      end
   end

   // ---------------- stage 5: operand and post term ----------------
   efpt_pkg::val_type  e4 [3];
   efpt_pkg::val_type  u_in [3];
   efpt_pkg::wide_type pa_in [3];
   efpt_pkg::wide_type sum_w;
   logic               f5_in;
   efpt_pkg::val_type  u5_ff [3];
   efpt_pkg::wide_type pa5_ff [3];
   efpt_pkg::wide_type pa6_ff [3];
   efpt_pkg::wide_type pa7_ff [3];
   logic               tr5_ff;

   assign e4[0] = e0_4_ff;
   assign e4[1] = e1_4_ff;
   assign e4[2] = '0;

   always_comb begin
      f5_in = f4_ff;
      for (int j = 0; j < 3; j++) begin
         u_in[j]  = v4_ff[j];
         pa_in[j] = '0;
         sum_w    = '0;
         unique case (m4_ff)
            efpt_pkg::MODE_PT2WORLD: begin
               pa_in[j] = efpt_pkg::wide_type'(t62[j]);
            end
            efpt_pkg::MODE_WORLD2PT: begin
               sum_w   = efpt_pkg::wide_type'(v4_ff[j]) - efpt_pkg::wide_type'(t62[j]);
               u_in[j] = efpt_pkg::sat62(sum_w);
               f5_in   = f5_in | efpt_pkg::ovf62(sum_w);
            end
            efpt_pkg::MODE_VEL2WORLD: begin
               sum_w   = efpt_pkg::wide_type'(v4_ff[j]) + efpt_pkg::wide_type'(e4[j]);
               u_in[j] = efpt_pkg::sat62(sum_w);
               f5_in   = f5_in | efpt_pkg::ovf62(sum_w);
            end
            default: begin
               pa_in[j] = -efpt_pkg::wide_type'(e4[j]);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[5]) begin
         u5_ff  <= u_in;
         pa5_ff <= pa_in;
         tr5_ff <= (m4_ff == efpt_pkg::MODE_WORLD2PT) || (m4_ff == efpt_pkg::MODE_VEL2VEH);
         f5_ff  <= f5_in;
      end
   end

   // ---------------- stage 6: matrix partial products ----------------
   efpt_pkg::mat_type msel [3][3];
   efpt_pkg::pp_type  pl6_ff [3][3];
   efpt_pkg::pp_type  ph6_ff [3][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            msel[i][j] = tr5_ff ? mat_ff[j][i] : mat_ff[i][j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[6]) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               pl6_ff[i][j] <= efpt_pkg::pp_lo(msel[i][j], u5_ff[j]);
               ph6_ff[i][j] <= efpt_pkg::pp_hi(msel[i][j], u5_ff[j]);
            end
         end
         pa6_ff <= pa5_ff;
         f6_ff  <= f5_ff;
      end
   end

   // ---------------- stage 7: row sums ----------------
   efpt_pkg::wide_type d_w [3];
   efpt_pkg::val_type  d7_ff [3];
   logic               f7_in;

   always_comb begin
      f7_in = f6_ff;
      for (int i = 0; i < 3; i++) begin
         d_w[i] = efpt_pkg::dot_fin(pl6_ff[i][0], pl6_ff[i][1], pl6_ff[i][2],
                                    ph6_ff[i][0], ph6_ff[i][1], ph6_ff[i][2]);
         f7_in  = f7_in | efpt_pkg::ovf62(d_w[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[7]) begin
         for (int i = 0; i < 3; i++) begin
            d7_ff[i] <= efpt_pkg::sat62(d_w[i]);
         end
         pa7_ff <= pa6_ff;
         f7_ff  <= f7_in;
      end
   end

   // ---------------- stage 8: add translation or ego term ----------------
   efpt_pkg::wide_type o_w [3];
   efpt_pkg::val_type  o8_ff [3];
   logic               f8_in;

   always_comb begin
      f8_in = f7_ff;
      for (int i = 0; i < 3; i++) begin
         o_w[i] = efpt_pkg::wide_type'(d7_ff[i]) + pa7_ff[i];
         f8_in  = f8_in | efpt_pkg::ovf62(o_w[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[8]) begin
         for (int i = 0; i < 3; i++) begin
            o8_ff[i] <= efpt_pkg::sat62(o_w[i]);
         end
         f8_ff <= f8_in;
      end
   end

   // ---------------- stage 9: clamp to output width ----------------
   efpt_pkg::wide_type     ow [3];
   efpt_pkg::wide_type     oc [3];
   logic [COORD_WIDTH-1:0] out_in [3];
   logic [COORD_WIDTH-1:0] out_ff [3];
   logic                   f9_in, f9_ff;

   always_comb begin
      f9_in = f8_ff;
      for (int i = 0; i < 3; i++) begin
         ow[i] = efpt_pkg::wide_type'(o8_ff[i]);
         priority if (ow[i] > OUT_MAX) begin
            oc[i] = OUT_MAX;
            f9_in = 1'b1;
         end else if (ow[i] < OUT_MIN) begin
            oc[i] = OUT_MIN;
            f9_in = 1'b1;
         end else begin
            oc[i] = ow[i];
         end
         out_in[i] = oc[i][COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[9]) begin
         out_ff <= out_in;
         f9_ff  <= f9_in;
      end
   end

   assign rsp_out_x     = out_ff[0];
   assign rsp_out_y     = out_ff[1];
   assign rsp_out_z     = out_ff[2];
   assign rsp_saturated = f9_ff;

endmodule

// File: hw/rtl/efpt_sincos.sv
// Pipelined sine and cosine of an angle in degrees, Q30 results.
module efpt_sincos (
   input  logic              clock,
   input  efpt_pkg::ang_type angle,
   output efpt_pkg::mat_type sin_out,
   output efpt_pkg::mat_type cos_out
);

   localparam int NPIPE = 2 * efpt_pkg::SC_STEPS + 2;

   logic signed [26:0] a_ext;
   logic signed [26:0] red_in;
   logic [24:0]        red_ff;
   logic [24:0]        fdiff;
   logic [1:0]         quad_in, quad2_ff, quad3_ff;
   logic [22:0]        frac_in, frac_ff;
   logic [22:0]        hdiff;
   logic [21:0]        h_in, h_ff;
   logic               swap_in, swap3_ff;
   logic [48:0]        xprod;
   logic [59:0]        x2prod;
   logic [60:0]        sprod;
   logic [30:0]        fs_in, fc_in, fs_ff, fc_ff;
   logic [1:0]         fq_ff;
   efpt_pkg::mat_type  s0, c0, sin_in, cos_in, sin_ff, cos_ff;
   efpt_pkg::sc_lane_type pipe_ff [NPIPE];
   efpt_pkg::sc_lane_type lane0_in, lane1_in;

   // Sine series product x2 * ts, Q30
   function automatic logic [30:0] ps_of(input efpt_pkg::sc_lane_type l);
      logic [60:0] p;
      p = 61'(l.x2) * 61'(l.ts);
      return p[60:30];
   endfunction

   // Reduce the angle into [0, 360)
   always_comb begin
      a_ext = 27'(angle);
      priority if (a_ext < -efpt_pkg::A360) begin
         red_in = a_ext + efpt_pkg::A720;
      end else if (a_ext < 27'sd0) begin
         red_in = a_ext + efpt_pkg::A360;
      end else if (a_ext >= efpt_pkg::A360) begin
         red_in = a_ext - efpt_pkg::A360;
      end else begin
         red_in = a_ext;
      end
   end

   // Split into quadrant and remainder
   always_comb begin
      priority if (red_ff >= efpt_pkg::D270) begin
         quad_in = 2'd3;
         fdiff   = red_ff - efpt_pkg::D270;
      end else if (red_ff >= efpt_pkg::D180) begin
         quad_in = 2'd2;
         fdiff   = red_ff - efpt_pkg::D180;
      end else if (red_ff >= efpt_pkg::D90) begin
         quad_in = 2'd1;
         fdiff   = red_ff - efpt_pkg::D90;
      end else begin
         quad_in = 2'd0;
         fdiff   = red_ff;
      end
      frac_in = fdiff[22:0];
   end

   // Fold the remainder into [0, 45]
   always_comb begin
      hdiff = efpt_pkg::D90F - frac_ff;
      if (frac_ff <= efpt_pkg::D45F) begin
         h_in    = frac_ff[21:0];
         swap_in = 1'b0;
      end else begin
         h_in    = hdiff[21:0];
         swap_in = 1'b1;
      end
   end

   // Radians and radians squared
   always_comb begin
      xprod         = 49'(h_ff) * 49'(efpt_pkg::DEG2RAD_K);
      lane0_in.x    = xprod[47:18];
      lane0_in.x2   = '0;
      lane0_in.ts   = efpt_pkg::Q30_ONE;
      lane0_in.tc   = efpt_pkg::Q30_ONE;
      lane0_in.quad = quad3_ff;
      lane0_in.swap = swap3_ff;
      x2prod        = 60'(pipe_ff[0].x) * 60'(pipe_ff[0].x);
      lane1_in      = pipe_ff[0];
      lane1_in.x2   = x2prod[59:30];
   end

   always_ff @(posedge clock) begin
      red_ff     <= red_in[24:0];
      quad2_ff   <= quad_in;
      frac_ff    <= frac_in;
      quad3_ff   <= quad2_ff;
      h_ff       <= h_in;
      swap3_ff   <= swap_in;
      pipe_ff[0] <= lane0_in;
      pipe_ff[1] <= lane1_in;
   end

   // Horner steps: multiply stage, then divide-and-subtract stage
   for (genvar i = 0; i < efpt_pkg::SC_STEPS; i++) begin : g_step
      efpt_pkg::sc_lane_type mul_in, div_in;
      logic [60:0]           pc;

      always_comb begin
         mul_in    = pipe_ff[1+2*i];
         pc        = 61'(pipe_ff[1+2*i].x2) * 61'(pipe_ff[1+2*i].tc);
         mul_in.tc = pc[60:30];
         div_in    = pipe_ff[2+2*i];
         div_in.tc = efpt_pkg::Q30_ONE - efpt_pkg::div_k(pipe_ff[2+2*i].tc,
                                                          efpt_pkg::KC[i], efpt_pkg::MC[i]);
         if (i < efpt_pkg::SIN_STEPS) begin
            mul_in.ts = ps_of(pipe_ff[1+2*i]);
            div_in.ts = efpt_pkg::Q30_ONE - efpt_pkg::div_k(pipe_ff[2+2*i].ts,
                                                             efpt_pkg::KS[i], efpt_pkg::MS[i]);
         end
      end

      always_ff @(posedge clock) begin
         pipe_ff[2+2*i] <= mul_in;
         pipe_ff[3+2*i] <= div_in;
      end
   end

   // Sine from the series, undo the fold
   always_comb begin
      sprod = 61'(pipe_ff[NPIPE-1].x) * 61'(pipe_ff[NPIPE-1].ts);
      if (pipe_ff[NPIPE-1].swap) begin
         fs_in = pipe_ff[NPIPE-1].tc;
         fc_in = sprod[60:30];
      end else begin
         fs_in = sprod[60:30];
         fc_in = pipe_ff[NPIPE-1].tc;
      end
   end

   // Map by quadrant
   always_comb begin
      s0 = $signed({3'b000, fs_ff});
      c0 = $signed({3'b000, fc_ff});
      unique case (fq_ff)
         2'd0: begin
            sin_in = s0;
            cos_in = c0;
         end
         2'd1: begin
            sin_in = c0;
            cos_in = -s0;
         end
         2'd2: begin
            sin_in = -s0;
            cos_in = -c0;
         end
         default: begin
            sin_in = -c0;
            cos_in = s0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      fs_ff  <= fs_in;
      fc_ff  <= fc_in;
      fq_ff  <= pipe_ff[NPIPE-1].quad;
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end

   assign sin_out = sin_ff;
   assign cos_out = cos_ff;

endmodule
